### rtl/core/ppca_pkg.sv
// Shared types, codes and constants of the polygon containment and area block.
`default_nettype none
package ppca_pkg;

	localparam int COORD_W          = 16;
	localparam int AREA_W           = 41;
	localparam int STATUS_W         = 2;
	localparam int VCNT_W           = 13;
	localparam int DEF_MAX_VERTICES = 256;
	localparam int DEF_COORD_BITS   = 16;
	localparam int Q_DEPTH          = 2;
	localparam int Q_PTR_W          = 1;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_TEST   = 2'd2,
		ACT_AREA   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_SHORT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CMD_CLEAR,
		CMD_STORE,
		CMD_DROP,
		CMD_TEST,
		CMD_TEST_SHORT,
		CMD_AREA,
		CMD_AREA_SHORT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t                     op;
		logic signed [COORD_W-1:0]   x;
		logic signed [COORD_W-1:0]   y;
		logic                        last;
		logic        [VCNT_W-1:0]    cnt;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_FIN
	} back_state_t;

endpackage
`default_nettype wire

### rtl/core/ppca_front.sv
// Front end: accepts input words, tracks the vertex count and classifies each word.
`default_nettype none
module ppca_front
	import ppca_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                action,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_y,
	input  wire logic                      last,
	input  wire logic                      q_full,
	output logic                           q_push,
	output cmd_t                           q_cmd
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	logic [CNT_W-1:0] count_q;
	logic             has_room;
	logic             too_few;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign has_room = count_q < CNT_W'(MAX_VERTICES);
	assign too_few  = count_q < CNT_W'(3);

	always_comb begin
		q_cmd.x    = coord_x;
		q_cmd.y    = coord_y;
		q_cmd.last = last;
		q_cmd.cnt  = VCNT_W'(count_q);
		unique case (action_t'(action))
			ACT_CLEAR:  q_cmd.op = CMD_CLEAR;
			ACT_APPEND: q_cmd.op = has_room ? CMD_STORE : CMD_DROP;
			ACT_TEST:   q_cmd.op = too_few ? CMD_TEST_SHORT : CMD_TEST;
			ACT_AREA:   q_cmd.op = too_few ? CMD_AREA_SHORT : CMD_AREA;
			default:    q_cmd.op = CMD_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			if (action_t'(action) == ACT_CLEAR) begin
				count_q <= '0;
			end else if (action_t'(action) == ACT_APPEND && has_room) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/ppca_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none
module ppca_queue
	import ppca_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      head_vld,
	output cmd_t      head_cmd
);

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   fill_q;

	assign full     = fill_q == (Q_PTR_W+1)'(Q_DEPTH);
	assign head_vld = fill_q != '0;
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (Q_PTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (Q_PTR_W+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/ppca_back.sv
// Back end: vertex memory, edge walk, crossing and shoelace datapath, result register.
`default_nettype none
module ppca_back
	import ppca_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int COORD_BITS   = DEF_COORD_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     q_vld,
	input  cmd_t                          q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [STATUS_W-1:0]           status,
	output logic                          inside_res,
	output logic                          all_inside,
	output logic signed [AREA_W-1:0]      twice_area
);

	localparam int CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int OP_W  = CW + 1;
	localparam int P_W   = 2 * OP_W;
	localparam int D_W   = P_W + 1;
	localparam int ACC_W = D_W + CNT_W;
	localparam int SAT_W = (ACC_W > AREA_W) ? ACC_W : AREA_W;
	localparam logic signed [SAT_W-1:0] AREA_HI =
		{{(SAT_W-AREA_W+1){1'b0}}, {(AREA_W-1){1'b1}}};
	localparam logic signed [SAT_W-1:0] AREA_LO =
		{{(SAT_W-AREA_W+1){1'b1}}, {(AREA_W-1){1'b0}}};

	logic signed [CW-1:0] mem_x [MAX_VERTICES];
	logic signed [CW-1:0] mem_y [MAX_VERTICES];

	back_state_t state_q, state_d;
	logic        start_walk, simple_done, fin_done;
	logic        is_walk_op, out_free;

	// command context of the walk in progress
	logic signed [CW-1:0] px_q, py_q;
	logic                 last_q, area_mode_q;
	logic [CNT_W-1:0]     n_q;

	// read issue
	logic                 rd_on_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 rd_end;

	// read data
	logic                 rd_vld_s1, rd_first_s1, rd_last_s1;
	logic signed [CW-1:0] rd_x_s1, rd_y_s1;

	// edge builder
	logic signed [CW-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;
	logic                 close_q;
	logic                 edge_vld;
	logic signed [CW-1:0] ea_x, ea_y, eb_x, eb_y;
	logic                 a_up, b_up;

	// operand and product stages
	logic                   vld_s2, end_s2, str_s2, dypos_s2;
	logic signed [OP_W-1:0] opa1_s2, opb1_s2, opa2_s2, opb2_s2;
	logic                   vld_s3, end_s3, str_s3, dypos_s3;
	logic signed [P_W-1:0]  p1_s3, p2_s3;
	logic signed [D_W-1:0]  diff;
	logic                   diff_pos, diff_neg;

	logic                    parity_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SAT_W-1:0] acc_ext;
	logic signed [AREA_W-1:0] area_sat;
	logic                    run_q;
	logic                    run_all;

	assign out_free   = !out_valid || !out_stall;
	assign is_walk_op = q_head.op == CMD_TEST || q_head.op == CMD_AREA;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		start_walk  = 1'b0;
		simple_done = 1'b0;
		fin_done    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_vld) begin
					if (is_walk_op) begin
						q_pop      = 1'b1;
						start_walk = 1'b1;
						state_d    = BK_WALK;
					end else if (out_free) begin
						q_pop       = 1'b1;
						simple_done = 1'b1;
					end
				end
			end
			BK_WALK: begin
				if (vld_s3 && end_s3) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				if (out_free) begin
					fin_done = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start_walk) begin
			px_q        <= q_head.x[CW-1:0];
			py_q        <= q_head.y[CW-1:0];
			last_q      <= q_head.last;
			area_mode_q <= q_head.op == CMD_AREA;
			n_q         <= q_head.cnt[CNT_W-1:0];
		end
	end

	// vertex memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (simple_done && q_head.op == CMD_STORE) begin
			mem_x[q_head.cnt[IDX_W-1:0]] <= q_head.x[CW-1:0];
			mem_y[q_head.cnt[IDX_W-1:0]] <= q_head.y[CW-1:0];
		end
		if (rd_on_q) begin
			rd_x_s1 <= mem_x[rd_idx_q];
			rd_y_s1 <= mem_y[rd_idx_q];
		end
	end

	assign rd_end = CNT_W'(rd_idx_q) == n_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_on_q     <= 1'b0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			close_q     <= 1'b0;
		end else begin
			if (start_walk) begin
				rd_on_q  <= 1'b1;
				rd_idx_q <= '0;
			end else if (rd_on_q) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
				if (rd_end) begin
					rd_on_q <= 1'b0;
				end
			end
			rd_vld_s1   <= rd_on_q;
			rd_first_s1 <= rd_on_q && rd_idx_q == '0;
			rd_last_s1  <= rd_on_q && rd_end;
			close_q     <= rd_vld_s1 && rd_last_s1;
		end
	end

	// join each vertex to the one before; close back to the first after the last
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			prev_x_q <= rd_x_s1;
			prev_y_q <= rd_y_s1;
			if (rd_first_s1) begin
				first_x_q <= rd_x_s1;
				first_y_q <= rd_y_s1;
			end
		end
	end

	assign edge_vld = (rd_vld_s1 && !rd_first_s1) || close_q;
	assign ea_x     = prev_x_q;
	assign ea_y     = prev_y_q;
	assign eb_x     = close_q ? first_x_q : rd_x_s1;
	assign eb_y     = close_q ? first_y_q : rd_y_s1;
	assign a_up     = ea_y > py_q;
	assign b_up     = eb_y > py_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= edge_vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		end_s2   <= close_q;
		str_s2   <= a_up != b_up;
		dypos_s2 <= b_up;
		if (area_mode_q) begin
			opa1_s2 <= OP_W'(ea_x);
			opb1_s2 <= OP_W'(eb_y);
			opa2_s2 <= OP_W'(eb_x);
			opb2_s2 <= OP_W'(ea_y);
		end else begin
			opa1_s2 <= OP_W'(eb_x) - OP_W'(ea_x);
			opb1_s2 <= OP_W'(py_q) - OP_W'(ea_y);
			opa2_s2 <= OP_W'(px_q) - OP_W'(ea_x);
			opb2_s2 <= OP_W'(eb_y) - OP_W'(ea_y);
		end
		end_s3   <= end_s2;
		str_s3   <= str_s2;
		dypos_s3 <= dypos_s2;
		p1_s3    <= P_W'(opa1_s2) * P_W'(opb1_s2);
		p2_s3    <= P_W'(opa2_s2) * P_W'(opb2_s2);
	end

	assign diff     = D_W'(p1_s3) - D_W'(p2_s3);
	assign diff_neg = diff[D_W-1];
	assign diff_pos = !diff_neg && diff != '0;

	always_ff @(posedge clk) begin
		if (start_walk) begin
			parity_q <= 1'b0;
			acc_q    <= '0;
		end else if (vld_s3) begin
			if (area_mode_q) begin
				acc_q <= acc_q + ACC_W'(diff);
			end else if (str_s3 && ((dypos_s3 && diff_pos) || (!dypos_s3 && diff_neg))) begin
				parity_q <= !parity_q;
			end
		end
	end

	assign acc_ext  = SAT_W'(acc_q);
	assign area_sat = (acc_ext > AREA_HI) ? AREA_HI[AREA_W-1:0] :
		(acc_ext < AREA_LO) ? AREA_LO[AREA_W-1:0] : acc_ext[AREA_W-1:0];
	assign run_all  = run_q && parity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			if (simple_done && q_head.op == CMD_CLEAR) begin
				run_q <= 1'b1;
			end else if (simple_done && q_head.op == CMD_TEST_SHORT) begin
				run_q <= q_head.last;
			end else if (fin_done && !area_mode_q) begin
				run_q <= last_q || run_all;
			end
			if (simple_done || fin_done) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (simple_done) begin
			inside_res <= 1'b0;
			all_inside <= 1'b0;
			twice_area <= '0;
			unique case (q_head.op)
				CMD_DROP:                      status <= STS_FULL;
				CMD_TEST_SHORT, CMD_AREA_SHORT: status <= STS_SHORT;
				default:                       status <= STS_OK;
			endcase
		end else if (fin_done) begin
			status     <= STS_OK;
			inside_res <= !area_mode_q && parity_q;
			all_inside <= !area_mode_q && run_all;
			twice_area <= area_mode_q ? area_sat : '0;
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == BK_IDLE)
		else $error("command taken from queue outside idle");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == BK_WALK)
		else $error("vertex read outside an edge walk");

	a_close_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && end_s3 |=> state_q == BK_FIN)
		else $error("closing edge did not end the walk");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(simple_done || fin_done) |-> out_free)
		else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

### rtl/core/polygon_point_containment_area_unit.sv
// Top level of the polygon containment and area block.
// Input channel (in_valid/in_stall) carries action, coord_x, coord_y and last; the
// output channel (out_valid/out_stall) carries status, inside_res, all_inside and
// twice_area, one result word per input word, in order.
// Actions: clear polygon, append vertex, test point, report twice the signed area.
// The front end counts vertices and classifies words into a two-entry queue; the
// back end executes one command at a time.
// Clear, append and commands on a polygon of fewer than three vertices are handled
// in the idle state: the command is registered in the queue entry and then in the
// result register, and such words can follow one per cycle while out_stall is low.
// A point test or area request walks the n stored edges through the single read
// port of the vertex memory, one vertex per cycle, then a two-stage multiply and
// accumulate: the result word is registered once the closing edge has been summed,
// and the back end takes the next command only after that result is registered.
// Reset empties the polygon, sets the run flag and drops any queued words; the
// vertex memory is not cleared and needs no sweep.
// While out_stall is high the result is held; the queue keeps accepting input
// words until it is full, then in_stall rises.
`default_nettype none
module polygon_point_containment_area_unit
	import ppca_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int COORD_BITS   = DEF_COORD_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                action,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_y,
	input  wire logic                      last,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [STATUS_W-1:0]            status,
	output logic                           inside_res,
	output logic                           all_inside,
	output logic signed [AREA_W-1:0]       twice_area
);

	logic q_full, q_push, q_pop, q_vld;
	cmd_t q_cmd, q_head;

	ppca_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action  (action),
		.coord_x (coord_x),
		.coord_y (coord_y),
		.last    (last),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (q_cmd)
	);

	ppca_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.head_vld(q_vld),
		.head_cmd(q_head)
	);

	ppca_back #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_vld     (q_vld),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.inside_res(inside_res),
		.all_inside(all_inside),
		.twice_area(twice_area)
	);

endmodule
`default_nettype wire
